>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the eigensystem matrix block.
// Depends on nothing; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define EFEM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property check failed");
// Check that a condition never holds outside reset.
`define EFEM_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define EFEM_ASSERT(name, clk, rst, prop)
`define EFEM_NEVER(name, clk, rst, cond)
`endif
`endif

>>> hdl/efem_pkg.sv
// Package of the ellipse-fit eigensystem matrix block: types, address map,
// scaling limits and the microprogram ROM. Depends on nothing.
`default_nettype none

package efem_pkg;

   localparam int unsigned NumWords = 21;
   localparam int unsigned MemDepth = 46;

   typedef logic [5:0] addr_type;
   typedef logic [6:0] pc_type;

   localparam addr_type AddrNone = 6'd0;
   localparam addr_type AddrDet  = 6'd27;
   localparam pc_type   EmitStart = 7'd99;
   localparam pc_type   ProgLast  = 7'd118;

   // magnitude limits that pick the scaling shift
   localparam logic [63:0] Lim32 = 64'd4294967296;
   localparam logic [63:0] Lim40 = 64'd1099511627776;
   localparam logic [63:0] Lim48 = 64'd281474976710656;
   localparam logic [63:0] Lim56 = 64'd72057594037927936;

   typedef enum logic [2:0] {
      OP_MAC, OP_SHSEL, OP_SCALE, OP_TEST, OP_DIV, OP_MFIN, OP_EMIT, OP_END
   } op_type;

   typedef enum logic [1:0] {
      KIND_M   = 2'd0,
      KIND_T   = 2'd1,
      KIND_DET = 2'd2
   } kind_type;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC} state_type;

   // multiply-accumulate flags: {first, neg, wr, trk}
   localparam logic [3:0] MacFirst = 4'b1000;
   localparam logic [3:0] MacNeg   = 4'b0100;
   localparam logic [3:0] MacWr    = 4'b0010;
   localparam logic [3:0] MacTrk   = 4'b0001;

   typedef struct packed {
      op_type      op;
      addr_type    src_a;
      addr_type    src_b;
      addr_type    dst;
      logic        first;
      logic        neg;
      logic        wr;
      logic        trk;
      logic        half;
      logic        last;
      kind_type    kind;
      logic [3:0]  idx;
      pc_type      target;
   } ucode_type;

   function automatic ucode_type uc_mac(addr_type a, addr_type b, logic [3:0] fl,
                                        addr_type d);
      ucode_type w;
      w       = '0;
      w.op    = OP_MAC;
      w.src_a = a;
      w.src_b = b;
      w.dst   = d;
      w.first = fl[3];
      w.neg   = fl[2];
      w.wr    = fl[1];
      w.trk   = fl[0];
      return w;
   endfunction

   function automatic ucode_type uc_op(op_type op, addr_type a, addr_type d);
      ucode_type w;
      w       = '0;
      w.op    = op;
      w.src_a = a;
      w.dst   = d;
      return w;
   endfunction

   function automatic ucode_type uc_test(addr_type a, pc_type tgt);
      ucode_type w;
      w        = '0;
      w.op     = OP_TEST;
      w.src_a  = a;
      w.target = tgt;
      return w;
   endfunction

   function automatic ucode_type uc_mfin(addr_type a, addr_type d, logic half);
      ucode_type w;
      w       = '0;
      w.op    = OP_MFIN;
      w.src_a = a;
      w.dst   = d;
      w.half  = half;
      return w;
   endfunction

   function automatic ucode_type uc_emit(kind_type k, logic [3:0] i, addr_type a,
                                         logic last);
      ucode_type w;
      w       = '0;
      w.op    = OP_EMIT;
      w.src_a = a;
      w.kind  = k;
      w.idx   = i;
      w.last  = last;
      return w;
   endfunction

   // Microprogram. Store map: scatter 0..20, adj 21..26, det 27, T 28..36, M 37..45.
   function automatic ucode_type ucode_fetch(pc_type pc);
      ucode_type w;
      w = '0;
      unique case (pc)
         // adjugate of the lower-right block, then its determinant
         7'd0:   w = uc_mac(6'd18, 6'd20, MacFirst, AddrNone);
         7'd1:   w = uc_mac(6'd19, 6'd19, MacNeg | MacWr, 6'd21);
         7'd2:   w = uc_mac(6'd16, 6'd20, MacFirst | MacNeg, AddrNone);
         7'd3:   w = uc_mac(6'd19, 6'd17, MacWr, 6'd22);
         7'd4:   w = uc_mac(6'd16, 6'd19, MacFirst, AddrNone);
         7'd5:   w = uc_mac(6'd18, 6'd17, MacNeg | MacWr, 6'd23);
         7'd6:   w = uc_mac(6'd15, 6'd20, MacFirst, AddrNone);
         7'd7:   w = uc_mac(6'd17, 6'd17, MacNeg | MacWr, 6'd24);
         7'd8:   w = uc_mac(6'd15, 6'd19, MacFirst | MacNeg, AddrNone);
         7'd9:   w = uc_mac(6'd16, 6'd17, MacWr, 6'd25);
         7'd10:  w = uc_mac(6'd15, 6'd18, MacFirst, AddrNone);
         7'd11:  w = uc_mac(6'd16, 6'd16, MacNeg | MacWr, 6'd26);
         7'd12:  w = uc_mac(6'd15, 6'd21, MacFirst, AddrNone);
         7'd13:  w = uc_mac(6'd16, 6'd22, 4'b0000, AddrNone);
         7'd14:  w = uc_mac(6'd17, 6'd23, MacWr, AddrDet);
         // T = -adj * S2^T, tracking the largest magnitude
         7'd15:  w = uc_mac(6'd21, 6'd3, MacFirst | MacNeg, AddrNone);
         7'd16:  w = uc_mac(6'd22, 6'd4, MacNeg, AddrNone);
         7'd17:  w = uc_mac(6'd23, 6'd5, MacNeg | MacWr | MacTrk, 6'd28);
         7'd18:  w = uc_mac(6'd21, 6'd4, MacFirst | MacNeg, AddrNone);
         7'd19:  w = uc_mac(6'd22, 6'd9, MacNeg, AddrNone);
         7'd20:  w = uc_mac(6'd23, 6'd10, MacNeg | MacWr | MacTrk, 6'd29);
         7'd21:  w = uc_mac(6'd21, 6'd9, MacFirst | MacNeg, AddrNone);
         7'd22:  w = uc_mac(6'd22, 6'd13, MacNeg, AddrNone);
         7'd23:  w = uc_mac(6'd23, 6'd14, MacNeg | MacWr | MacTrk, 6'd30);
         7'd24:  w = uc_mac(6'd22, 6'd3, MacFirst | MacNeg, AddrNone);
         7'd25:  w = uc_mac(6'd24, 6'd4, MacNeg, AddrNone);
         7'd26:  w = uc_mac(6'd25, 6'd5, MacNeg | MacWr | MacTrk, 6'd31);
         7'd27:  w = uc_mac(6'd22, 6'd4, MacFirst | MacNeg, AddrNone);
         7'd28:  w = uc_mac(6'd24, 6'd9, MacNeg, AddrNone);
         7'd29:  w = uc_mac(6'd25, 6'd10, MacNeg | MacWr | MacTrk, 6'd32);
         7'd30:  w = uc_mac(6'd22, 6'd9, MacFirst | MacNeg, AddrNone);
         7'd31:  w = uc_mac(6'd24, 6'd13, MacNeg, AddrNone);
         7'd32:  w = uc_mac(6'd25, 6'd14, MacNeg | MacWr | MacTrk, 6'd33);
         7'd33:  w = uc_mac(6'd23, 6'd3, MacFirst | MacNeg, AddrNone);
         7'd34:  w = uc_mac(6'd25, 6'd4, MacNeg, AddrNone);
         7'd35:  w = uc_mac(6'd26, 6'd5, MacNeg | MacWr | MacTrk, 6'd34);
         7'd36:  w = uc_mac(6'd23, 6'd4, MacFirst | MacNeg, AddrNone);
         7'd37:  w = uc_mac(6'd25, 6'd9, MacNeg, AddrNone);
         7'd38:  w = uc_mac(6'd26, 6'd10, MacNeg | MacWr | MacTrk, 6'd35);
         7'd39:  w = uc_mac(6'd23, 6'd9, MacFirst | MacNeg, AddrNone);
         7'd40:  w = uc_mac(6'd25, 6'd13, MacNeg, AddrNone);
         7'd41:  w = uc_mac(6'd26, 6'd14, MacNeg | MacWr | MacTrk, 6'd36);
         // pick the shift, scale T and det
         7'd42:  w = uc_op(OP_SHSEL, AddrNone, AddrNone);
         7'd43:  w = uc_op(OP_SCALE, 6'd28, 6'd28);
         7'd44:  w = uc_op(OP_SCALE, 6'd29, 6'd29);
         7'd45:  w = uc_op(OP_SCALE, 6'd30, 6'd30);
         7'd46:  w = uc_op(OP_SCALE, 6'd31, 6'd31);
         7'd47:  w = uc_op(OP_SCALE, 6'd32, 6'd32);
         7'd48:  w = uc_op(OP_SCALE, 6'd33, 6'd33);
         7'd49:  w = uc_op(OP_SCALE, 6'd34, 6'd34);
         7'd50:  w = uc_op(OP_SCALE, 6'd35, 6'd35);
         7'd51:  w = uc_op(OP_SCALE, 6'd36, 6'd36);
         7'd52:  w = uc_op(OP_SCALE, AddrDet, AddrDet);
         // a zero determinant skips the M words
         7'd53:  w = uc_test(AddrDet, EmitStart);
         // M0..M2
         7'd54:  w = uc_mac(6'd28, 6'd3, MacFirst, AddrNone);
         7'd55:  w = uc_mac(6'd31, 6'd4, 4'b0000, AddrNone);
         7'd56:  w = uc_mac(6'd34, 6'd5, 4'b0000, AddrNone);
         7'd57:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd58:  w = uc_mfin(6'd0, 6'd37, 1'b1);
         7'd59:  w = uc_mac(6'd29, 6'd3, MacFirst, AddrNone);
         7'd60:  w = uc_mac(6'd32, 6'd4, 4'b0000, AddrNone);
         7'd61:  w = uc_mac(6'd35, 6'd5, 4'b0000, AddrNone);
         7'd62:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd63:  w = uc_mfin(6'd1, 6'd38, 1'b1);
         7'd64:  w = uc_mac(6'd30, 6'd3, MacFirst, AddrNone);
         7'd65:  w = uc_mac(6'd33, 6'd4, 4'b0000, AddrNone);
         7'd66:  w = uc_mac(6'd36, 6'd5, 4'b0000, AddrNone);
         7'd67:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd68:  w = uc_mfin(6'd2, 6'd39, 1'b1);
         // M3..M5, negated
         7'd69:  w = uc_mac(6'd28, 6'd4, MacFirst, AddrNone);
         7'd70:  w = uc_mac(6'd31, 6'd9, 4'b0000, AddrNone);
         7'd71:  w = uc_mac(6'd34, 6'd10, 4'b0000, AddrNone);
         7'd72:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd73:  w = uc_mfin(6'd1, 6'd40, 1'b0);
         7'd74:  w = uc_mac(6'd29, 6'd4, MacFirst, AddrNone);
         7'd75:  w = uc_mac(6'd32, 6'd9, 4'b0000, AddrNone);
         7'd76:  w = uc_mac(6'd35, 6'd10, 4'b0000, AddrNone);
         7'd77:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd78:  w = uc_mfin(6'd6, 6'd41, 1'b0);
         7'd79:  w = uc_mac(6'd30, 6'd4, MacFirst, AddrNone);
         7'd80:  w = uc_mac(6'd33, 6'd9, 4'b0000, AddrNone);
         7'd81:  w = uc_mac(6'd36, 6'd10, 4'b0000, AddrNone);
         7'd82:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd83:  w = uc_mfin(6'd7, 6'd42, 1'b0);
         // M6..M8
         7'd84:  w = uc_mac(6'd28, 6'd9, MacFirst, AddrNone);
         7'd85:  w = uc_mac(6'd31, 6'd13, 4'b0000, AddrNone);
         7'd86:  w = uc_mac(6'd34, 6'd14, 4'b0000, AddrNone);
         7'd87:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd88:  w = uc_mfin(6'd2, 6'd43, 1'b1);
         7'd89:  w = uc_mac(6'd29, 6'd9, MacFirst, AddrNone);
         7'd90:  w = uc_mac(6'd32, 6'd13, 4'b0000, AddrNone);
         7'd91:  w = uc_mac(6'd35, 6'd14, 4'b0000, AddrNone);
         7'd92:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd93:  w = uc_mfin(6'd7, 6'd44, 1'b1);
         7'd94:  w = uc_mac(6'd30, 6'd9, MacFirst, AddrNone);
         7'd95:  w = uc_mac(6'd33, 6'd13, 4'b0000, AddrNone);
         7'd96:  w = uc_mac(6'd36, 6'd14, 4'b0000, AddrNone);
         7'd97:  w = uc_op(OP_DIV, AddrDet, AddrNone);
         7'd98:  w = uc_mfin(6'd11, 6'd45, 1'b1);
         // emit M, T, det
         7'd99:  w = uc_emit(KIND_M, 4'd0, 6'd37, 1'b0);
         7'd100: w = uc_emit(KIND_M, 4'd1, 6'd38, 1'b0);
         7'd101: w = uc_emit(KIND_M, 4'd2, 6'd39, 1'b0);
         7'd102: w = uc_emit(KIND_M, 4'd3, 6'd40, 1'b0);
         7'd103: w = uc_emit(KIND_M, 4'd4, 6'd41, 1'b0);
         7'd104: w = uc_emit(KIND_M, 4'd5, 6'd42, 1'b0);
         7'd105: w = uc_emit(KIND_M, 4'd6, 6'd43, 1'b0);
         7'd106: w = uc_emit(KIND_M, 4'd7, 6'd44, 1'b0);
         7'd107: w = uc_emit(KIND_M, 4'd8, 6'd45, 1'b0);
         7'd108: w = uc_emit(KIND_T, 4'd0, 6'd28, 1'b0);
         7'd109: w = uc_emit(KIND_T, 4'd1, 6'd29, 1'b0);
         7'd110: w = uc_emit(KIND_T, 4'd2, 6'd30, 1'b0);
         7'd111: w = uc_emit(KIND_T, 4'd3, 6'd31, 1'b0);
         7'd112: w = uc_emit(KIND_T, 4'd4, 6'd32, 1'b0);
         7'd113: w = uc_emit(KIND_T, 4'd5, 6'd33, 1'b0);
         7'd114: w = uc_emit(KIND_T, 4'd6, 6'd34, 1'b0);
         7'd115: w = uc_emit(KIND_T, 4'd7, 6'd35, 1'b0);
         7'd116: w = uc_emit(KIND_T, 4'd8, 6'd36, 1'b0);
         7'd117: w = uc_emit(KIND_DET, 4'd0, AddrDet, 1'b1);
         default: w = uc_op(OP_END, AddrNone, AddrNone);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> hdl/efem_if.sv
// Channel interfaces of the eigensystem matrix block: load beats in, results out.
// Valid/ready handshake; depends on nothing.
`default_nettype none

interface efem_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         entry_index;
   logic signed [63:0] entry_value;
   logic               compute_now;

   modport source(output valid, entry_index, entry_value, compute_now, input ready);
   modport sink(input valid, entry_index, entry_value, compute_now, output ready);
endinterface

interface efem_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [3:0]         result_index;
   logic signed [63:0] result_value;
   logic               divide_error;
   logic               last_result;

   modport source(output valid, result_kind, result_index, result_value, divide_error,
                  last_result, input ready);
   modport sink(input valid, result_kind, result_index, result_value, divide_error,
                last_result, output ready);
endinterface

`default_nettype wire

>>> hdl/efem_divider.sv
// Signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
// Standalone; used by the top level for the nine quotient steps.
`default_nettype none

module efem_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);

   logic [6:0]  count_ff, count_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dmag_ff, dmag_in;
   logic [64:0] rem_shift;
   logic        fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, quo_ff[63]};
   assign fits      = rem_shift >= {1'b0, dmag_ff};

   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dmag_in  = dmag_ff;
      if (start) begin
         count_in = 7'd64;
         neg_in   = dividend[63] ^ divisor[63];
         rem_in   = '0;
         quo_in   = dividend[63] ? 64'(-dividend) : dividend;
         dmag_in  = divisor[63] ? 64'(-divisor) : divisor;
      end else if (count_ff != 7'd0) begin
         count_in = count_ff - 7'd1;
         done_in  = (count_ff == 7'd1);
         rem_in   = fits ? 64'(rem_shift - {1'b0, dmag_ff}) : rem_shift[63:0];
         quo_in   = {quo_ff[62:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
   end

   // restore the sign; the most negative value over -1 wraps on its own
   assign done     = done_ff;
   assign quotient = neg_ff ? 64'(-quo_ff) : quo_ff;

endmodule

`default_nettype wire

>>> hdl/ellipse_fit_eigensystem_matrix_unit.sv
// Ellipse-fit reduced scatter matrix unit. Load beats write one 64-bit word of the
// packed upper triangle of the 6x6 scatter matrix and are taken one per cycle; a beat
// with compute_now set starts a run that forms adj(S3), det(S3), T, the scaling shift
// and M, then returns nineteen result beats (M0..M8, T0..T8, det). A run with a zero
// determinant skips the nine quotients, and the result side can hold off any run. The
// divider is bit-serial, and each step of the 64-bit multiply-accumulate reads its
// operands and then builds the product on a single 32x32 multiplier set.
// No load is taken until the run ends.
`default_nettype none
`include "assert_macros.svh"

module ellipse_fit_eigensystem_matrix_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   efem_req_if.sink    req_chan,
   efem_rsp_if.source  rsp_chan
);

   efem_pkg::state_type  state_ff, state_in;
   efem_pkg::pc_type     pc_ff, pc_in;
   efem_pkg::ucode_type  ins;
   logic [1:0]           sub_ff, sub_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          prod_ff, prod_in;
   logic [63:0]          max_ff, max_in;
   logic [5:0]           shift_ff, shift_in;
   logic                 err_ff, err_in;
   logic [63:0]          rd_a_ff, rd_b_ff;

   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           out_kind_ff, out_kind_in;
   logic [3:0]           out_idx_ff, out_idx_in;
   logic [63:0]          out_value_ff, out_value_in;
   logic                 out_err_ff, out_err_in;
   logic                 out_last_ff, out_last_in;

   logic [63:0]          mem [efem_pkg::MemDepth];
   logic                 mem_we;
   efem_pkg::addr_type   mem_wa;
   logic [63:0]          mem_wd;

   logic [31:0]          mul_x, mul_y;
   logic [63:0]          mul_p;
   logic [63:0]          mac_sum, mac_mag;
   logic [63:0]          mfin_sum, mfin_val;
   logic [63:0]          scaled;
   logic                 div_start, div_done;
   logic [63:0]          div_q;

   assign ins = efem_pkg::ucode_fetch(pc_ff);

   // pick one 32-bit partial product per multiply cycle
   assign mul_x = sub_ff[1] ? rd_a_ff[63:32] : rd_a_ff[31:0];
   assign mul_y = (sub_ff == 2'd1) ? rd_b_ff[63:32] : rd_b_ff[31:0];
   assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

   assign mac_sum  = (ins.first ? 64'd0 : acc_ff) + (ins.neg ? 64'(-prod_ff) : prod_ff);
   assign mac_mag  = mac_sum[63] ? 64'(-mac_sum) : mac_sum;
   assign mfin_sum = acc_ff + rd_a_ff;
   assign mfin_val = ins.half ? 64'($signed(mfin_sum + {63'd0, mfin_sum[63]}) >>> 1)
                              : 64'(-mfin_sum);
   assign scaled   = 64'($signed(rd_a_ff) >>> shift_ff);

   efem_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (rd_a_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // sequencer: fetch, read operands, execute the control word
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      sub_in       = sub_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      max_in       = max_ff;
      shift_in     = shift_ff;
      err_in       = err_ff;
      mem_we       = 1'b0;
      mem_wa       = ins.dst;
      mem_wd       = mac_sum;
      div_start    = 1'b0;
      req_chan.ready = 1'b0;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_kind_in  = out_kind_ff;
      out_idx_in   = out_idx_ff;
      out_value_in = out_value_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         efem_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               mem_we = (32'(req_chan.entry_index) < efem_pkg::NumWords);
               mem_wa = {1'b0, req_chan.entry_index};
               mem_wd = req_chan.entry_value;
               if (req_chan.compute_now) begin
                  pc_in    = '0;
                  err_in   = 1'b0;
                  max_in   = '0;
                  state_in = efem_pkg::ST_READ;
               end
            end
         end
         efem_pkg::ST_READ: begin
            sub_in   = '0;
            state_in = efem_pkg::ST_EXEC;
         end
         efem_pkg::ST_EXEC: begin
            unique case (ins.op)
               efem_pkg::OP_MAC: begin
                  unique case (sub_ff)
                     2'd0: prod_in = mul_p;
                     2'd1, 2'd2: prod_in = prod_ff + {mul_p[31:0], 32'd0};
                     default: begin
                        acc_in = mac_sum;
                        mem_we = ins.wr;
                        if (ins.trk && (mac_mag > max_ff)) begin
                           max_in = mac_mag;
                        end
                        pc_in    = pc_ff + 7'd1;
                        state_in = efem_pkg::ST_READ;
                     end
                  endcase
                  sub_in = sub_ff + 2'd1;
               end
               efem_pkg::OP_SHSEL: begin
                  priority if (max_ff <= efem_pkg::Lim32) shift_in = 6'd0;
                  else if (max_ff <= efem_pkg::Lim40) shift_in = 6'd8;
                  else if (max_ff < efem_pkg::Lim48) shift_in = 6'd16;
                  else if (max_ff < efem_pkg::Lim56) shift_in = 6'd24;
                  else shift_in = 6'd32;
                  pc_in    = pc_ff + 7'd1;
                  state_in = efem_pkg::ST_READ;
               end
               efem_pkg::OP_SCALE: begin
                  mem_we   = 1'b1;
                  mem_wd   = scaled;
                  pc_in    = pc_ff + 7'd1;
                  state_in = efem_pkg::ST_READ;
               end
               efem_pkg::OP_TEST: begin
                  err_in   = (rd_a_ff == 64'd0);
                  pc_in    = (rd_a_ff == 64'd0) ? ins.target : pc_ff + 7'd1;
                  state_in = efem_pkg::ST_READ;
               end
               efem_pkg::OP_DIV: begin
                  if (sub_ff == 2'd0) begin
                     div_start = 1'b1;
                     sub_in    = 2'd1;
                  end else if (div_done) begin
                     acc_in   = div_q;
                     pc_in    = pc_ff + 7'd1;
                     state_in = efem_pkg::ST_READ;
                  end
               end
               efem_pkg::OP_MFIN: begin
                  mem_we   = 1'b1;
                  mem_wd   = mfin_val;
                  pc_in    = pc_ff + 7'd1;
                  state_in = efem_pkg::ST_READ;
               end
               efem_pkg::OP_EMIT: begin
                  // hold until the output register is free
                  if (!out_valid_ff || rsp_chan.ready) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = ins.kind;
                     out_idx_in   = ins.idx;
                     out_value_in = (ins.kind == efem_pkg::KIND_M && err_ff) ? 64'd0
                                                                             : rd_a_ff;
                     out_err_in   = err_ff;
                     out_last_in  = ins.last;
                     pc_in        = pc_ff + 7'd1;
                     state_in     = efem_pkg::ST_READ;
                  end
               end
               default: state_in = efem_pkg::ST_IDLE;
            endcase
         end
         default: state_in = efem_pkg::ST_IDLE;
      endcase
   end

   // working store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (state_ff == efem_pkg::ST_READ) begin
         rd_a_ff <= mem[ins.src_a];
         rd_b_ff <= mem[ins.src_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efem_pkg::ST_IDLE;
         pc_ff        <= '0;
         sub_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sub_ff       <= sub_in;
         out_valid_ff <= out_valid_in;
      end
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      max_ff       <= max_in;
      shift_ff     <= shift_in;
      err_ff       <= err_in;
      out_kind_ff  <= out_kind_in;
      out_idx_ff   <= out_idx_in;
      out_value_ff <= out_value_in;
      out_err_ff   <= out_err_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_kind  = out_kind_ff;
   assign rsp_chan.result_index = out_idx_ff;
   assign rsp_chan.result_value = out_value_ff;
   assign rsp_chan.divide_error = out_err_ff;
   assign rsp_chan.last_result  = out_last_ff;

   `EFEM_ASSERT(a_last_is_det, clock, reset, rsp_chan.valid && rsp_chan.last_result |-> rsp_chan.result_kind == efem_pkg::KIND_DET)
   `EFEM_ASSERT(a_err_zero_m, clock, reset, rsp_chan.valid && rsp_chan.divide_error && rsp_chan.result_kind == efem_pkg::KIND_M |-> rsp_chan.result_value == 64'd0)
   `EFEM_ASSERT(a_pc_in_prog, clock, reset, state_ff != efem_pkg::ST_IDLE |-> pc_ff <= efem_pkg::ProgLast)
   `EFEM_NEVER(a_div_on_err, clock, reset, state_ff == efem_pkg::ST_EXEC && ins.op == efem_pkg::OP_DIV && err_ff)
   `EFEM_ASSERT(a_done_in_div, clock, reset, div_done |-> state_ff == efem_pkg::ST_EXEC && ins.op == efem_pkg::OP_DIV)

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking bench for ellipse_fit_eigensystem_matrix_unit: loads scatter words,
// starts runs and checks each result beat against a bit-exact predictor.
// Depends on efem_pkg and the channel interfaces in hdl/efem_if.sv.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StallLimit = 40000;
   localparam int unsigned HoldCycles = 3000;
   localparam logic [63:0] MaxWord = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MinWord = 64'h8000_0000_0000_0000;

   typedef struct {
      efem_pkg::kind_type kind;
      logic [3:0]  idx;
      logic [63:0] value;
      logic        err;
      logic        last;
   } result_beat_type;

   // Scoreboard: own copy of the scatter store and the queue of pending results.
   class result_board_type;
      logic [63:0]     scatter[efem_pkg::NumWords];
      result_beat_type pending[$];

      function new();
         foreach (scatter[i]) scatter[i] = '0;
      endfunction

      function logic [63:0] mag(logic [63:0] v);
         return v[63] ? -v : v;
      endfunction

      function logic [63:0] quot(logic [63:0] a, logic [63:0] b);
         logic [63:0] q;
         q = mag(a) / mag(b);
         return (a[63] != b[63]) ? -q : q;
      endfunction

      function logic [63:0] dot3(logic [63:0] a0, logic [63:0] b0, logic [63:0] a1,
                                 logic [63:0] b1, logic [63:0] a2, logic [63:0] b2);
         return a0 * b0 + a1 * b1 + a2 * b2;
      endfunction

      function void push(efem_pkg::kind_type k, int i, logic [63:0] v, logic e,
                         logic l);
         result_beat_type r;
         r.kind = k;
         r.idx = i[3:0];
         r.value = v;
         r.err = e;
         r.last = l;
         pending.push_back(r);
      endfunction

      // Store the word, then predict the full run when one is requested.
      function void note_load(logic [4:0] idx, logic [63:0] val, logic go);
         logic [63:0] s[efem_pkg::NumWords];
         logic [63:0] adj[6];
         logic [63:0] tw[9];
         logic [63:0] q[9];
         logic [63:0] mw[9];
         logic [63:0] det;
         logic [63:0] peak;
         int          sh;
         logic        err;
         if (idx < efem_pkg::NumWords) scatter[idx] = val;
         if (!go) return;
         s = scatter;
         adj[0] = s[18] * s[20] - s[19] * s[19];
         adj[1] = -(s[16] * s[20] - s[19] * s[17]);
         adj[2] = s[16] * s[19] - s[18] * s[17];
         adj[3] = s[15] * s[20] - s[17] * s[17];
         adj[4] = -(s[15] * s[19] - s[16] * s[17]);
         adj[5] = s[15] * s[18] - s[16] * s[16];
         det = dot3(s[15], adj[0], s[16], adj[1], s[17], adj[2]);
         tw[0] = -dot3(adj[0], s[3], adj[1], s[4], adj[2], s[5]);
         tw[1] = -dot3(adj[0], s[4], adj[1], s[9], adj[2], s[10]);
         tw[2] = -dot3(adj[0], s[9], adj[1], s[13], adj[2], s[14]);
         tw[3] = -dot3(adj[1], s[3], adj[3], s[4], adj[4], s[5]);
         tw[4] = -dot3(adj[1], s[4], adj[3], s[9], adj[4], s[10]);
         tw[5] = -dot3(adj[1], s[9], adj[3], s[13], adj[4], s[14]);
         tw[6] = -dot3(adj[2], s[3], adj[4], s[4], adj[5], s[5]);
         tw[7] = -dot3(adj[2], s[4], adj[4], s[9], adj[5], s[10]);
         tw[8] = -dot3(adj[2], s[9], adj[4], s[13], adj[5], s[14]);
         // pick the shift from the largest magnitude
         peak = '0;
         foreach (tw[i]) if (mag(tw[i]) > peak) peak = mag(tw[i]);
         if (peak <= efem_pkg::Lim32) sh = 0;
         else if (peak <= efem_pkg::Lim40) sh = 8;
         else if (peak < efem_pkg::Lim48) sh = 16;
         else if (peak < efem_pkg::Lim56) sh = 24;
         else sh = 32;
         foreach (tw[i]) tw[i] = $unsigned($signed(tw[i]) >>> sh);
         det = $unsigned($signed(det) >>> sh);
         err = (det == 0);
         foreach (mw[i]) mw[i] = '0;
         if (!err) begin
            q[0] = quot(dot3(tw[0], s[3], tw[3], s[4], tw[6], s[5]), det);
            q[1] = quot(dot3(tw[1], s[3], tw[4], s[4], tw[7], s[5]), det);
            q[2] = quot(dot3(tw[2], s[3], tw[5], s[4], tw[8], s[5]), det);
            q[3] = quot(dot3(tw[0], s[4], tw[3], s[9], tw[6], s[10]), det);
            q[4] = quot(dot3(tw[1], s[4], tw[4], s[9], tw[7], s[10]), det);
            q[5] = quot(dot3(tw[2], s[4], tw[5], s[9], tw[8], s[10]), det);
            q[6] = quot(dot3(tw[0], s[9], tw[3], s[13], tw[6], s[14]), det);
            q[7] = quot(dot3(tw[1], s[9], tw[4], s[13], tw[7], s[14]), det);
            q[8] = quot(dot3(tw[2], s[9], tw[5], s[13], tw[8], s[14]), det);
            mw[0] = quot(q[0] + s[0], 64'd2);
            mw[1] = quot(q[1] + s[1], 64'd2);
            mw[2] = quot(q[2] + s[2], 64'd2);
            mw[3] = -(q[3] + s[1]);
            mw[4] = -(q[4] + s[6]);
            mw[5] = -(q[5] + s[7]);
            mw[6] = quot(q[6] + s[2], 64'd2);
            mw[7] = quot(q[7] + s[7], 64'd2);
            mw[8] = quot(q[8] + s[11], 64'd2);
         end
         for (int i = 0; i < 9; i++) push(efem_pkg::KIND_M, i, mw[i], err, 1'b0);
         for (int i = 0; i < 9; i++) push(efem_pkg::KIND_T, i, tw[i], err, 1'b0);
         push(efem_pkg::KIND_DET, 0, det, err, 1'b1);
      endfunction

      // Compare one result beat with the oldest prediction; empty string on match.
      function string check_result(logic [1:0] k, logic [3:0] i, logic [63:0] v,
                                   logic e, logic l);
         result_beat_type r;
         if (pending.size() == 0)
            return $sformatf("unexpected result kind=%0d idx=%0d", k, i);
         r = pending.pop_front();
         if (k != r.kind || i != r.idx || v != r.value || e != r.err || l != r.last)
            return $sformatf("got k=%0d i=%0d v=%h e=%b l=%b, want k=%0d i=%0d v=%h e=%b l=%b",
                             k, i, v, e, l, r.kind, r.idx, r.value, r.err, r.last);
         return "";
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   efem_req_if req_bus();
   efem_rsp_if rsp_bus();

   ellipse_fit_eigensystem_matrix_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   result_board_type board = new();
   int unsigned errors = 0;
   int unsigned send_idle = 38;
   int unsigned recv_idle = 63;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_req = 1'b0;

   always #4 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.entry_index = '0;
      req_bus.entry_value = '0;
      req_bus.compute_now = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   // Receiver: a requested long hold-off first, else random back-pressure.
   always @(negedge clock) begin
      if (hold_req && hold_left == 0) begin
         hold_left = HoldCycles;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= recv_idle);
      end
   end

   // Check result beats and watch for a stalled run.
   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            msg = board.check_result(rsp_bus.result_kind, rsp_bus.result_index,
                                     rsp_bus.result_value, rsp_bus.divide_error,
                                     rsp_bus.last_result);
            if (msg != "") report(msg);
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("watchdog: no beat for %0d cycles", StallLimit);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Offer one load beat; called and returns at a falling edge.
   task automatic send_load(logic [4:0] idx, logic [63:0] val, logic go);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.entry_index = idx;
      req_bus.entry_value = val;
      req_bus.compute_now = go;
      do @(posedge clock); while (!req_bus.ready);
      board.note_load(idx, val, go);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      case ($urandom_range(3))
         0: w = 64'($signed($urandom_range(2000)) - 1000);
         1: begin
            w = {$urandom, $urandom} >> $urandom_range(63, 40);
            if ($urandom_range(1)) w = -w;
         end
         2: w = {$urandom, $urandom};
         default: begin
            case ($urandom_range(4))
               0: w = '0;
               1: w = 64'd1;
               2: w = '1;
               3: w = MaxWord;
               default: w = MinWord;
            endcase
         end
      endcase
      return w;
   endfunction

   int unsigned sent;

   // Random traffic: mostly partial or full reloads ending in a run, some noise.
   task automatic random_phase(int unsigned count);
      int unsigned pick;
      int unsigned n;
      int unsigned stop;
      stop = sent + count;
      while (sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            n = $urandom_range(8, 1);
            for (int unsigned k = 1; k <= n; k++)
               send_load(5'($urandom_range(efem_pkg::NumWords - 1)), rand_word(), k == n);
            sent += n;
         end else if (pick < 85) begin
            for (int k = 0; k < efem_pkg::NumWords; k++)
               send_load(5'(k), rand_word(), k == efem_pkg::NumWords - 1);
            sent += efem_pkg::NumWords;
         end else begin
            send_load(5'($urandom_range(31, efem_pkg::NumWords)), rand_word(),
                      1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full load set up so that one quotient divides the most negative word by -1
      for (int k = 0; k < efem_pkg::NumWords; k++) begin
         logic [63:0] v;
         case (k)
            15: v = '1;
            18, 20: v = 64'd1;
            3: v = 64'd1 << 31;
            4: v = 64'd1 << 32;
            default: v = '0;
         endcase
         send_load(5'(k), v, k == efem_pkg::NumWords - 1);
      end
      // clear the corner of the lower block: zero determinant
      send_load(5'd15, '0, 1'b1);
      // out-of-range index still runs
      send_load(5'd25, MaxWord, 1'b1);
      send_load(5'd0, MaxWord, 1'b1);
      send_load(5'd20, MinWord, 1'b1);
      send_load(5'd31, MinWord, 1'b0);
      sent = 26;

      random_phase(130);
      send_idle = 63;
      recv_idle = 38;
      random_phase(130);
      send_idle = 0;
      recv_idle = 0;
      hold_req = 1'b1;
      random_phase(130);

      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

`default_nettype wire
